### rtl/ssvg_pkg.sv
// ----------------------------------------------------------------------------
// ssvg_pkg
// Shared constants, types and trig tables of the shape strip vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssvg_pkg;

	// Geometry setup
	localparam int ROUND_SEGMENTS   = 12;
	localparam int ELLIPSE_SEGMENTS = 65;
	localparam int TRIG_BITS        = 16;

	// Trig values hold +-1.0 exactly, so they need one bit above TRIG_BITS
	localparam int TRIG_W = TRIG_BITS + 1;
	localparam int RAD_W  = 27;
	localparam int PROD_W = TRIG_W + RAD_W;
	localparam int SUM_W  = 32;
	localparam int CI_W   = $clog2(ROUND_SEGMENTS);
	localparam int EI_W   = $clog2(ELLIPSE_SEGMENTS - 1);
	localparam int CNT_W  = 9;

	localparam longint unsigned CORNER_DEN  = longint'(4 * (ROUND_SEGMENTS - 1));
	localparam longint unsigned ELL_DEN     = longint'(ELLIPSE_SEGMENTS - 1);
	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int              TRIG_SHIFT  = 31 - TRIG_BITS;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE  = TRIG_W'(1) <<< (TRIG_BITS - 1);
	localparam logic signed [SUM_W-1:0]  COORD_MAX = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0]  COORD_MIN = -SUM_W'(8388608);
	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (TRIG_BITS - 1);

	// Strip lengths
	localparam logic [CNT_W-1:0] CNT_FILL_RECT    = CNT_W'(6);
	localparam logic [CNT_W-1:0] CNT_STROKE_RECT  = CNT_W'(16);
	localparam logic [CNT_W-1:0] CNT_STROKE_ROUND = CNT_W'(8 * ROUND_SEGMENTS + 4);
	localparam logic [CNT_W-1:0] CNT_FILL_ROUND   = CNT_W'(4 * ROUND_SEGMENTS + 8);
	localparam logic [CNT_W-1:0] CNT_ELLIPSE      = CNT_W'(2 * ELLIPSE_SEGMENTS + 2);

	// Taylor divisors for sine and cosine terms
	localparam longint unsigned SIN_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};
	localparam longint unsigned COS_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

	typedef enum logic [2:0] {
		OP_FILL_RECT    = 3'd0,
		OP_STROKE_RECT  = 3'd1,
		OP_STROKE_ROUND = 3'd2,
		OP_FILL_ROUND   = 3'd3,
		OP_STROKE_ELL   = 3'd4,
		OP_FILL_ELL     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		MODE_RECT    = 2'd0,
		MODE_CORNER  = 2'd1,
		MODE_ELLIPSE = 2'd2
	} mode_t;

	// Radius choice: none gives a zero offset, mid the plain doubled radius
	typedef enum logic [1:0] {
		RAD_NONE = 2'd0,
		RAD_MID  = 2'd1,
		RAD_IN   = 2'd2,
		RAD_OUT  = 2'd3
	} rad_t;

	typedef struct packed {
		mode_t           mode;
		rad_t            rad;
		logic [1:0]      which;   // bit 0 right, bit 1 bottom
		logic [CI_W-1:0] ci;
		logic [EI_W-1:0] ei;
		logic            dx;
		logic            dy;
		logic            negx;
		logic            negy;
		logic            last;
		logic            err;
	} dec_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [23:0] shape_x;
		logic signed [23:0] shape_y;
		logic [22:0]        size_w;
		logic [22:0]        size_h;
		logic [22:0]        corner_radius;
		logic [22:0]        stroke_width;
		logic [31:0]        fill_color;
		logic [7:0]         vertex_index;
	} cmd_t;

	// Rectangle corner order: value is {right, bottom}; last two entries unused
	localparam logic [1:0] FILL_SEQ [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0};
	localparam logic [2:0] STRK_SEQ [16] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd3, 3'd2, 3'd4,
		3'd5, 3'd6, 3'd4, 3'd7, 3'd6, 3'd0, 3'd1, 3'd1};
	// Stroke rectangle vertex: {right, bottom, negate x offset, negate y offset}
	localparam logic [3:0] STRK_DEF [8] = '{4'b0000, 4'b0011, 4'b1001, 4'b1010,
		4'b1111, 4'b1100, 4'b0110, 4'b0101};

	typedef logic [ROUND_SEGMENTS-1:0][2*TRIG_W-1:0]    corner_tab_t;
	typedef logic [ELLIPSE_SEGMENTS-2:0][2*TRIG_W-1:0]  ell_tab_t;

	// Clamp a Q30 value to [0, 1] and round half up to the trig format
	function automatic logic signed [TRIG_W-1:0] trig_round(input longint v);
		longint c;
		c = v;
		if (c < 0) c = 0;
		if (c > longint'(Q30_ONE)) c = longint'(Q30_ONE);
		return TRIG_W'((c + (longint'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT);
	endfunction

	// Cosine and sine of 2pi * p / 2^32, returned as {cos, sin}
	function automatic logic [2*TRIG_W-1:0] trig_q(input longint unsigned p);
		longint unsigned r, x, x2, term;
		longint s, c;
		logic [1:0] q;
		logic signed [TRIG_W-1:0] sv, cv, co, si;
		q = p[31:30];
		r = p & (Q30_ONE - 1);
		x = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		s = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / SIN_DIV[k];
			if ((k & 1) != 0) s = s - longint'(term);
			else s = s + longint'(term);
		end
		term = Q30_ONE;
		c = longint'(Q30_ONE);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / COS_DIV[k];
			if ((k & 1) != 0) c = c - longint'(term);
			else c = c + longint'(term);
		end
		sv = trig_round(s);
		cv = trig_round(c);
		case (q)
			2'd0: begin co = cv; si = sv; end
			2'd1: begin co = -sv; si = cv; end
			2'd2: begin co = -cv; si = -sv; end
			default: begin co = sv; si = -cv; end
		endcase
		return {co, si};
	endfunction

	// Corner table: entry i is at angle -i * pi / (2 * (ROUND_SEGMENTS - 1))
	function automatic corner_tab_t corner_tab();
		corner_tab_t tab;
		longint unsigned a;
		for (int i = 0; i < ROUND_SEGMENTS; i++) begin
			a = (i == 0) ? 64'd0 : CORNER_DEN - longint'(i);
			tab[i] = trig_q((a << 32) / CORNER_DEN);
		end
		return tab;
	endfunction

	// Ellipse table: entry j is at angle j * 2pi / (ELLIPSE_SEGMENTS - 1)
	function automatic ell_tab_t ell_tab();
		ell_tab_t tab;
		for (int j = 0; j < ELLIPSE_SEGMENTS - 1; j++) begin
			tab[j] = trig_q((longint'(j) << 32) / ELL_DEN);
		end
		return tab;
	endfunction

	localparam corner_tab_t CORNER_TAB = corner_tab();
	localparam ell_tab_t    ELL_TAB    = ell_tab();

endpackage

`default_nettype wire

### rtl/ssvg_if.sv
// ----------------------------------------------------------------------------
// ssvg channel interfaces
// Command channel into the generator and vertex channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssvg_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [23:0] shape_x;
	logic signed [23:0] shape_y;
	logic [22:0]        size_w;
	logic [22:0]        size_h;
	logic [22:0]        corner_radius;
	logic [22:0]        stroke_width;
	logic [31:0]        fill_color;
	logic [7:0]         vertex_index;

	modport source (
		output valid, opcode, shape_x, shape_y, size_w, size_h,
		       corner_radius, stroke_width, fill_color, vertex_index,
		input  ready
	);
	modport sink (
		input  valid, opcode, shape_x, shape_y, size_w, size_h,
		       corner_radius, stroke_width, fill_color, vertex_index,
		output ready
	);
endinterface

interface ssvg_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] vertex_x;
	logic signed [23:0] vertex_y;
	logic [31:0]        vertex_color;
	logic               last_vertex;
	logic               index_error;

	modport source (
		output valid, vertex_x, vertex_y, vertex_color, last_vertex, index_error,
		input  ready
	);
	modport sink (
		input  valid, vertex_x, vertex_y, vertex_color, last_vertex, index_error,
		output ready
	);
endinterface

`default_nettype wire

### rtl/ssvg_decode.sv
// ----------------------------------------------------------------------------
// ssvg_decode
// Map opcode and strip position to corner, ellipse step and radius choice.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvg_decode
	import ssvg_pkg::*;
(
	input  wire logic [2:0] opcode,
	input  wire logic [7:0] vertex_index,
	output dec_t            dec
);

	localparam logic [CNT_W-1:0] S  = CNT_W'(ROUND_SEGMENTS);
	localparam logic [CNT_W-1:0] E  = CNT_W'(ELLIPSE_SEGMENTS);
	localparam logic [CNT_W-1:0] ED = CNT_W'(ELLIPSE_SEGMENTS - 1);

	logic [CNT_W-1:0] k, count, t, u, j, i, ie;
	logic [1:0]       seg;
	logic [1:0]       fc;
	logic [3:0]       sd;

	// Decode one strip position
	always_comb begin
		dec   = '0;
		k     = {1'b0, vertex_index};
		count = '0;
		t     = '0;
		u     = '0;
		j     = '0;
		i     = '0;
		ie    = '0;
		seg   = '0;
		fc    = FILL_SEQ[vertex_index[2:0]];
		sd    = STRK_DEF[STRK_SEQ[vertex_index[3:0]]];
		unique case (opcode)
			OP_FILL_RECT: begin
				count    = CNT_FILL_RECT;
				dec.mode = MODE_RECT;
				dec.rad  = RAD_NONE;
				dec.dx   = fc[1];
				dec.dy   = fc[0];
			end
			OP_STROKE_RECT: begin
				count    = CNT_STROKE_RECT;
				dec.mode = MODE_RECT;
				dec.rad  = RAD_MID;
				dec.dx   = sd[3];
				dec.dy   = sd[2];
				dec.negx = sd[1];
				dec.negy = sd[0];
			end
			OP_STROKE_ROUND: begin
				count    = CNT_STROKE_ROUND;
				dec.mode = MODE_CORNER;
				if (k <= CNT_W'(1)) begin
					dec.rad = RAD_IN;
				end else if (k < 2 * S) begin
					t = k - CNT_W'(2);
					if (t[0]) begin
						dec.ci  = CI_W'((t >> 1) + CNT_W'(1));
						dec.rad = RAD_IN;
					end else begin
						dec.ci  = CI_W'(t >> 1);
						dec.rad = RAD_OUT;
					end
				end else if (k == 2 * S) begin
					dec.ci  = CI_W'(S - CNT_W'(1));
					dec.rad = RAD_OUT;
				end else if (k < 8 * S + CNT_W'(1)) begin
					// Remaining three corners, two vertices per step
					t = k - (2 * S + CNT_W'(1));
					if (t >= 4 * S) begin
						seg = 2'd2;
						u   = t - 4 * S;
					end else if (t >= 2 * S) begin
						seg = 2'd1;
						u   = t - 2 * S;
					end else begin
						seg = 2'd0;
						u   = t;
					end
					j         = u >> 1;
					dec.ci    = (seg == 2'd1) ? CI_W'(j) : CI_W'(S - CNT_W'(1) - j);
					dec.which = (seg == 2'd0) ? 2'd1 : ((seg == 2'd1) ? 2'd3 : 2'd2);
					dec.rad   = t[0] ? RAD_OUT : RAD_IN;
				end else if (k == 8 * S + CNT_W'(1)) begin
					dec.rad = RAD_IN;
				end else begin
					dec.rad = RAD_OUT;
				end
			end
			OP_FILL_ROUND: begin
				count    = CNT_FILL_ROUND;
				dec.mode = MODE_CORNER;
				dec.rad  = RAD_MID;
				if (k == '0) begin
					dec.ci = CI_W'(S - CNT_W'(1));
				end else if (k <= 2 * S) begin
					t         = k - CNT_W'(1);
					dec.which = t[0] ? 2'd1 : 2'd0;
					dec.ci    = CI_W'(S - CNT_W'(1) - (t >> 1));
				end else if (k <= 2 * S + CNT_W'(3)) begin
					dec.which = 2'd1;
				end else if (k == 2 * S + CNT_W'(4)) begin
					dec.which = 2'd0;
				end else if (k == 2 * S + CNT_W'(5)) begin
					dec.which = 2'd3;
				end else if (k == 2 * S + CNT_W'(6)) begin
					dec.which = 2'd2;
				end else if (k <= 4 * S + CNT_W'(6)) begin
					t         = k - (2 * S + CNT_W'(7));
					dec.which = t[0] ? 2'd2 : 2'd3;
					dec.ci    = CI_W'(t >> 1);
				end else begin
					dec.which = 2'd2;
					dec.ci    = CI_W'(S - CNT_W'(1));
				end
			end
			OP_STROKE_ELL: begin
				count    = CNT_ELLIPSE;
				dec.mode = MODE_ELLIPSE;
				if (k == '0) begin
					dec.rad = RAD_IN;
				end else if (k <= 2 * E) begin
					t       = k - CNT_W'(1);
					i       = t >> 1;
					dec.rad = t[0] ? RAD_OUT : RAD_IN;
				end else begin
					i       = E - CNT_W'(1);
					dec.rad = RAD_OUT;
				end
				dec.ei = (i == ED) ? '0 : EI_W'(i);
			end
			OP_FILL_ELL: begin
				count    = CNT_ELLIPSE;
				dec.mode = MODE_ELLIPSE;
				dec.rad  = RAD_MID;
				if (k == '0) begin
					dec.rad = RAD_NONE;
				end else if (k <= 2 * E) begin
					t = k - CNT_W'(1);
					i = t >> 1;
					if (!t[0]) dec.rad = RAD_NONE;
				end else begin
					i = E - CNT_W'(1);
				end
				// Walk the ellipse backward
				ie     = (i == ED) ? '0 : i;
				dec.ei = (ie == '0) ? '0 : EI_W'(ED - ie);
			end
			default: begin
				count = '0;
			end
		endcase
		dec.err  = (k >= count);
		dec.last = !dec.err && (k == count - CNT_W'(1));
	end

endmodule

`default_nettype wire

### rtl/shape_strip_vertex_generator.sv
// ----------------------------------------------------------------------------
// shape_strip_vertex_generator
// Returns one triangle strip vertex of a rectangle, rounded rectangle or
// ellipse per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one shape command plus the vertex index wanted; vtx returns
//   that vertex with the command color, a last-vertex flag and an index
//   error flag (zero coordinates and color when the index is past the end).
//   Both channels transfer on valid and ready high at a rising clk edge.
//   A command is caught in an input register; the corner or ellipse trig
//   table read, one multiply, the rounding add and saturation then fill the
//   result register. A vertex thus passes the input register and then the result
//   register before it shows on vtx; one command is taken every cycle while vtx keeps up.
//   When vtx stalls the result holds and the input register keeps one more
//   command; cmd.ready drops only while both are full and vtx is stalled.
//   arst_n clears both valid flags at once; no command is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module shape_strip_vertex_generator
	import ssvg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssvg_cmd_if.sink   cmd,
	ssvg_vtx_if.source vtx
);

	cmd_t  cmd_s1;
	logic  valid_s1;
	logic  out_valid_q;
	logic  advance;
	dec_t  dec;

	logic signed [23:0] vx_q, vy_q;
	logic [31:0]        color_q;
	logic               last_q, err_q;

	logic signed [RAD_W-1:0]  px, py, pw, ph, pr, ps;
	logic signed [RAD_W-1:0]  r2, rin, rout, w2, h2;
	logic signed [RAD_W-1:0]  bx, by, rx, ry;
	logic signed [TRIG_W-1:0] cco, csi, eco, esi, tx, ty;
	logic signed [PROD_W-1:0] mx, my;
	logic signed [SUM_W-1:0]  sx, sy;
	logic signed [23:0]       satx, saty;

	// Result register frees when empty or taken
	assign advance   = !out_valid_q || vtx.ready;
	assign cmd.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{cmd.opcode, cmd.shape_x, cmd.shape_y, cmd.size_w, cmd.size_h,
				cmd.corner_radius, cmd.stroke_width, cmd.fill_color, cmd.vertex_index};
		end
	end

	ssvg_decode u_decode (
		.opcode       (cmd_s1.opcode),
		.vertex_index (cmd_s1.vertex_index),
		.dec          (dec)
	);

	// Widen the command fields
	assign px = RAD_W'(cmd_s1.shape_x);
	assign py = RAD_W'(cmd_s1.shape_y);
	assign pw = RAD_W'(cmd_s1.size_w);
	assign ph = RAD_W'(cmd_s1.size_h);
	assign pr = RAD_W'(cmd_s1.corner_radius);
	assign ps = RAD_W'(cmd_s1.stroke_width);

	// Doubled radii keep half a stroke width exact
	assign r2   = pr <<< 1;
	assign rin  = r2 - ps;
	assign rout = r2 + ps;
	assign w2   = pw <<< 1;
	assign h2   = ph <<< 1;

	// Trig table reads
	assign {cco, csi} = CORNER_TAB[dec.ci];
	assign {eco, esi} = ELL_TAB[dec.ei];

	// Select base point, trig factors and radii
	always_comb begin
		bx = px;
		by = py;
		tx = '0;
		ty = '0;
		rx = ps;
		ry = ps;
		case (dec.mode)
			MODE_CORNER: begin
				bx = dec.which[0] ? px + pw - pr : px + pr;
				by = dec.which[1] ? py + ph - pr : py + pr;
				tx = dec.which[0] ? cco : -cco;
				ty = dec.which[1] ? -csi : csi;
				case (dec.rad)
					RAD_IN:  rx = rin;
					RAD_OUT: rx = rout;
					default: rx = r2;
				endcase
				ry = rx;
			end
			MODE_ELLIPSE: begin
				if (dec.rad != RAD_NONE) begin
					tx = eco;
					ty = esi;
				end
				case (dec.rad)
					RAD_IN: begin
						rx = w2 - ps;
						ry = h2 - ps;
					end
					RAD_OUT: begin
						rx = w2 + ps;
						ry = h2 + ps;
					end
					default: begin
						rx = w2;
						ry = h2;
					end
				endcase
			end
			default: begin
				bx = dec.dx ? px + pw : px;
				by = dec.dy ? py + ph : py;
				if (dec.rad != RAD_NONE) begin
					tx = dec.negx ? -TRIG_ONE : TRIG_ONE;
					ty = dec.negy ? -TRIG_ONE : TRIG_ONE;
				end
			end
		endcase
	end

	// Scale, round half up and add to the base point
	assign mx = tx * rx;
	assign my = ty * ry;
	assign sx = SUM_W'(bx) + SUM_W'((mx + PROD_HALF) >>> TRIG_BITS);
	assign sy = SUM_W'(by) + SUM_W'((my + PROD_HALF) >>> TRIG_BITS);

	// Saturate to the coordinate range
	assign satx = (sx > COORD_MAX) ? 24'sh7FFFFF : ((sx < COORD_MIN) ? 24'sh800000 : sx[23:0]);
	assign saty = (sy > COORD_MAX) ? 24'sh7FFFFF : ((sy < COORD_MIN) ? 24'sh800000 : sy[23:0]);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			vx_q    <= dec.err ? '0 : satx;
			vy_q    <= dec.err ? '0 : saty;
			color_q <= dec.err ? '0 : cmd_s1.fill_color;
			last_q  <= dec.last;
			err_q   <= dec.err;
		end
	end

	assign vtx.valid        = out_valid_q;
	assign vtx.vertex_x     = vx_q;
	assign vtx.vertex_y     = vy_q;
	assign vtx.vertex_color = color_q;
	assign vtx.last_vertex  = last_q;
	assign vtx.index_error  = err_q;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape strip vertex generator testbench
// Drives shape commands with random gaps, predicts every strip vertex with an
// independent fixed-point model and checks each vertex transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import ssvg_pkg::*;
();

	localparam int NUM_RANDOM = 495;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int SS = ROUND_SEGMENTS;
	localparam int ES = ELLIPSE_SEGMENTS;

	typedef struct {
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic [31:0]        color;
		logic               last;
		logic               err;
	} vertex_t;

	typedef struct {
		longint x, y;
	} point_t;

	logic clk;
	logic arst_n;
	ssvg_cmd_if cmd ();
	ssvg_vtx_if vtx ();

	cmd_t    pending_cmds [$];
	vertex_t expected_vertices [$];
	int      fail_count;
	longint  cycle_count;
	int      send_gap;
	int      recv_gap;
	bit      stimulus_done;
	bit      hold_sender;

	shape_strip_vertex_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.vtx    (vtx.source)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Sine/cosine of 2pi*num/den: Q30 series over a quarter turn, rounded half up
	function automatic void angle_trig(input longint unsigned num, input longint unsigned den,
			output longint co, output longint si);
		longint unsigned p, r, x, x2, term;
		longint s, c, sq, cq;
		int q;
		if (den == 0) den = 1;
		p = ((num % den) << 32) / den;
		q = int'((p >> 30) & 3);
		r = p & ((64'd1 << 30) - 1);
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		s = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			s = (k % 2 == 1) ? s - longint'(term) : s + longint'(term);
		end
		term = 64'd1 << 30;
		c = longint'(term);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			c = (k % 2 == 1) ? c - longint'(term) : c + longint'(term);
		end
		if (s < 0) s = 0;
		if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
		if (c < 0) c = 0;
		if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
		sq = (s + (64'sd1 << (30 - TRIG_BITS))) >>> (31 - TRIG_BITS);
		cq = (c + (64'sd1 << (30 - TRIG_BITS))) >>> (31 - TRIG_BITS);
		case (q)
			0: begin co = cq; si = sq; end
			1: begin co = -sq; si = cq; end
			2: begin co = -cq; si = -sq; end
			default: begin co = sq; si = -cq; end
		endcase
	endfunction

	// Point on a rounded corner; which bit 0 is right, bit 1 is bottom
	function automatic point_t arc_point(input cmd_t c, input int which, input int i,
			input longint r2);
		longint unsigned den;
		longint co, si, cx, cy, x0, y0, w, h, r;
		point_t p;
		den = 4 * (SS - 1);
		x0 = c.shape_x; y0 = c.shape_y;
		w = c.size_w; h = c.size_h; r = c.corner_radius;
		angle_trig((den - i % den) % den, den, co, si);
		cx = (which & 1) ? x0 + w - r : x0 + r;
		cy = (which & 2) ? y0 + h - r : y0 + r;
		p.x = (cx <<< TRIG_BITS) + ((which & 1) ? co * r2 : -co * r2);
		p.y = (cy <<< TRIG_BITS) + ((which & 2) ? -si * r2 : si * r2);
		return p;
	endfunction

	function automatic point_t oval_point(input cmd_t c, input int i, input bit fwd,
			input longint rx2, input longint ry2);
		longint unsigned den;
		longint co, si, x0, y0;
		point_t p;
		den = ES - 1;
		x0 = c.shape_x; y0 = c.shape_y;
		angle_trig(fwd ? i % den : (den - i % den) % den, den, co, si);
		p.x = (x0 <<< TRIG_BITS) + co * rx2;
		p.y = (y0 <<< TRIG_BITS) + si * ry2;
		return p;
	endfunction

	function automatic logic signed [23:0] to_coord(input longint w);
		longint v;
		v = (w + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic vertex_t strip_vertex(input cmd_t c);
		int k, count, t, seg, j, i;
		int sides [3];
		int rect_fill [6];
		int rect_strk [16];
		int strk_def [8][4];
		longint x0, y0, w, h, r, s, in2, out2;
		point_t p;
		vertex_t v;
		sides = '{1, 3, 2};
		rect_fill = '{0, 0, 1, 2, 3, 3};
		rect_strk = '{0, 0, 1, 2, 0, 3, 2, 4, 5, 6, 4, 7, 6, 0, 1, 1};
		strk_def = '{'{0, 0, 1, 1}, '{0, 0, -1, -1}, '{1, 0, 1, -1}, '{1, 0, -1, 1},
			'{1, 1, -1, -1}, '{1, 1, 1, 1}, '{0, 1, -1, 1}, '{0, 1, 1, -1}};
		k = c.vertex_index;
		x0 = c.shape_x; y0 = c.shape_y;
		w = c.size_w; h = c.size_h; r = c.corner_radius; s = c.stroke_width;
		case (c.opcode)
			OP_FILL_RECT: count = 6;
			OP_STROKE_RECT: count = 16;
			OP_STROKE_ROUND: count = 8 * SS + 4;
			OP_FILL_ROUND: count = 4 * SS + 8;
			OP_STROKE_ELL, OP_FILL_ELL: count = 2 * ES + 2;
			default: count = 0;
		endcase
		if (k >= count) begin
			v = '{vx: '0, vy: '0, color: '0, last: 1'b0, err: 1'b1};
			return v;
		end
		case (c.opcode)
			OP_FILL_RECT: begin
				// corner code: bit 1 selects the right side, bit 0 the bottom
				p.x = (x0 + ((rect_fill[k] & 2) ? w : 0)) <<< TRIG_BITS;
				p.y = (y0 + ((rect_fill[k] & 1) ? h : 0)) <<< TRIG_BITS;
			end
			OP_STROKE_RECT: begin
				j = rect_strk[k];
				p.x = ((x0 + (strk_def[j][0] ? w : 0)) <<< TRIG_BITS)
					+ strk_def[j][2] * s * (64'sd1 <<< (TRIG_BITS - 1));
				p.y = ((y0 + (strk_def[j][1] ? h : 0)) <<< TRIG_BITS)
					+ strk_def[j][3] * s * (64'sd1 <<< (TRIG_BITS - 1));
			end
			OP_STROKE_ROUND: begin
				in2 = 2 * r - s; out2 = 2 * r + s;
				if (k <= 1) p = arc_point(c, 0, 0, in2);
				else if (k < 2 * SS) begin
					t = k - 2;
					p = (t & 1) ? arc_point(c, 0, (t >> 1) + 1, in2)
						: arc_point(c, 0, t >> 1, out2);
				end else if (k == 2 * SS) p = arc_point(c, 0, SS - 1, out2);
				else if (k < 8 * SS + 1) begin
					t = k - (2 * SS + 1);
					seg = t / (2 * SS); j = (t % (2 * SS)) >> 1;
					i = (seg == 1) ? j : SS - 1 - j;
					p = arc_point(c, sides[seg % 3], i, (t & 1) ? out2 : in2);
				end else if (k == 8 * SS + 1) p = arc_point(c, 0, 0, in2);
				else p = arc_point(c, 0, 0, out2);
			end
			OP_FILL_ROUND: begin
				in2 = 2 * r;
				if (k == 0) p = arc_point(c, 0, SS - 1, in2);
				else if (k <= 2 * SS) begin
					t = k - 1;
					p = arc_point(c, (t & 1) ? 1 : 0, SS - 1 - (t >> 1), in2);
				end else if (k <= 2 * SS + 3) p = arc_point(c, 1, 0, in2);
				else if (k == 2 * SS + 4) p = arc_point(c, 0, 0, in2);
				else if (k == 2 * SS + 5) p = arc_point(c, 3, 0, in2);
				else if (k == 2 * SS + 6) p = arc_point(c, 2, 0, in2);
				else if (k <= 4 * SS + 6) begin
					t = k - (2 * SS + 7);
					p = arc_point(c, (t & 1) ? 2 : 3, t >> 1, in2);
				end else p = arc_point(c, 2, SS - 1, in2);
			end
			OP_STROKE_ELL: begin
				if (k == 0) begin i = 0; j = 0; end
				else if (k <= 2 * ES) begin i = (k - 1) >> 1; j = (k - 1) & 1; end
				else begin i = ES - 1; j = 1; end
				if (j != 0) p = oval_point(c, i, 1'b1, 2 * w + s, 2 * h + s);
				else p = oval_point(c, i, 1'b1, 2 * w - s, 2 * h - s);
			end
			default: begin
				p.x = x0 <<< TRIG_BITS; p.y = y0 <<< TRIG_BITS;
				if (k > 2 * ES) p = oval_point(c, ES - 1, 1'b0, 2 * w, 2 * h);
				else if (k > 0 && ((k - 1) & 1))
					p = oval_point(c, (k - 1) >> 1, 1'b0, 2 * w, 2 * h);
			end
		endcase
		v.vx = to_coord(p.x);
		v.vy = to_coord(p.y);
		v.color = c.fill_color;
		v.last = (k == count - 1);
		v.err = 1'b0;
		return v;
	endfunction

	function automatic int strip_length(input logic [2:0] op);
		case (op)
			OP_FILL_RECT: return 6;
			OP_STROKE_RECT: return 16;
			OP_STROKE_ROUND: return 8 * SS + 4;
			OP_FILL_ROUND: return 4 * SS + 8;
			OP_STROKE_ELL, OP_FILL_ELL: return 2 * ES + 2;
			default: return 0;
		endcase
	endfunction

	function automatic logic [22:0] pick_size(input bit wide_range);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 23'h7FFFFF;
			2: return 23'($urandom);
			default: return wide_range ? 23'($urandom) : 23'($urandom_range(0, 20000));
		endcase
	endfunction

	function automatic logic signed [23:0] pick_pos();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 60000)) - 24'sd30000;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int n;
		c.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		c.shape_x = pick_pos();
		c.shape_y = pick_pos();
		c.size_w = pick_size(1'b0);
		c.size_h = pick_size(1'b0);
		c.corner_radius = pick_size(1'b0);
		c.stroke_width = pick_size(1'b0);
		c.fill_color = $urandom;
		n = strip_length(c.opcode);
		// mostly indices inside the strip, some past its end
		if (n > 0 && $urandom_range(0, 9) != 0) c.vertex_index = 8'($urandom_range(0, n - 1));
		else c.vertex_index = 8'($urandom);
		return c;
	endfunction

	initial begin
		cmd_t c;
		arst_n = 1'b0;
		fail_count = 0;
		stimulus_done = 1'b0;
		hold_sender = 1'b0;
		// Directed: every opcode over its full strip on a modest shape
		for (int op = 0; op < 8; op++) begin
			c = '{opcode: 3'(op), shape_x: 24'sd2560, shape_y: -24'sd1280,
				size_w: 23'd20000, size_h: 23'd12000, corner_radius: 23'd3000,
				stroke_width: 23'd700, fill_color: 32'hA5C3_0F1E, vertex_index: 8'd0};
			for (int k = 0; k <= strip_length(3'(op)) && k < 256; k++) begin
				c.vertex_index = 8'(k);
				pending_cmds.push_back(c);
			end
		end
		// Extremes: saturation, odd geometry, top index
		c = '{opcode: OP_STROKE_RECT, shape_x: 24'sh7FFFFF, shape_y: 24'sh800000,
			size_w: 23'h7FFFFF, size_h: 23'h7FFFFF, corner_radius: 23'h7FFFFF,
			stroke_width: 23'h7FFFFF, fill_color: 32'hFFFF_FFFF, vertex_index: 8'd5};
		pending_cmds.push_back(c);
		c.opcode = OP_STROKE_ROUND; c.vertex_index = 8'd30;
		pending_cmds.push_back(c);
		c.opcode = OP_FILL_ELL; c.vertex_index = 8'd3; c.shape_x = 24'sh800000;
		pending_cmds.push_back(c);
		c.opcode = OP_STROKE_ELL; c.vertex_index = 8'd255;
		pending_cmds.push_back(c);
		c = '{opcode: OP_STROKE_ROUND, shape_x: '0, shape_y: '0, size_w: '0, size_h: '0,
			corner_radius: 23'd10, stroke_width: 23'd5000, fill_color: '0, vertex_index: 8'd40};
		pending_cmds.push_back(c);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// Let the directed part drain completely before random traffic
		wait (pending_cmds.size() == 0);
		hold_sender = 1'b1;
		wait (expected_vertices.size() == 0);
		hold_sender = 1'b0;
		for (int n = 0; n < NUM_RANDOM; n++) pending_cmds.push_back(random_cmd());
		wait (pending_cmds.size() == 0);
		stimulus_done = 1'b1;
	end

	// Driver: present queued commands, with a random gap before each
	always @(posedge clk or negedge arst_n) begin
		int sgap;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			{cmd.opcode, cmd.shape_x, cmd.shape_y, cmd.size_w, cmd.size_h,
				cmd.corner_radius, cmd.stroke_width, cmd.fill_color,
				cmd.vertex_index} <= '0;
			send_gap <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				expected_vertices.push_back(strip_vertex(pending_cmds.pop_front()));
				sgap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				// a zero gap presents the next command right behind this one
				if (sgap == 0 && !hold_sender && pending_cmds.size() > 0) begin
					cmd.valid <= 1'b1;
					{cmd.opcode, cmd.shape_x, cmd.shape_y, cmd.size_w, cmd.size_h,
						cmd.corner_radius, cmd.stroke_width, cmd.fill_color,
						cmd.vertex_index} <= pending_cmds[0];
				end else begin
					cmd.valid <= 1'b0;
					send_gap <= (sgap > 0) ? sgap - 1 : 0;
				end
			end else if (!cmd.valid && send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (!cmd.valid && !hold_sender && pending_cmds.size() > 0) begin
				cmd.valid <= 1'b1;
				{cmd.opcode, cmd.shape_x, cmd.shape_y, cmd.size_w, cmd.size_h,
					cmd.corner_radius, cmd.stroke_width, cmd.fill_color,
					cmd.vertex_index} <= pending_cmds[0];
			end
		end
	end

	// Monitor: random stalls on vtx, compare each transfer with the oldest vertex
	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		int rgap;
		if (!arst_n) begin
			vtx.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (vtx.valid && vtx.ready) begin
				if (expected_vertices.size() == 0) begin
					$error("vertex transfer with nothing expected");
					fail_count++;
				end else begin
					e = expected_vertices.pop_front();
					if (vtx.vertex_x !== e.vx) begin
						$error("vertex_x expected %0d got %0d", e.vx, vtx.vertex_x);
						fail_count++;
					end
					if (vtx.vertex_y !== e.vy) begin
						$error("vertex_y expected %0d got %0d", e.vy, vtx.vertex_y);
						fail_count++;
					end
					if (vtx.vertex_color !== e.color) begin
						$error("vertex_color expected %h got %h", e.color, vtx.vertex_color);
						fail_count++;
					end
					if (vtx.last_vertex !== e.last) begin
						$error("last_vertex expected %b got %b", e.last, vtx.last_vertex);
						fail_count++;
					end
					if (vtx.index_error !== e.err) begin
						$error("index_error expected %b got %b", e.err, vtx.index_error);
						fail_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				vtx.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (vtx.valid && vtx.ready) begin
				// hold ready in bursts, otherwise draw a fresh stall
				rgap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
				if (rgap == 0) begin
					vtx.ready <= 1'b1;
				end else begin
					vtx.ready <= 1'b0;
					recv_gap <= rgap - 1;
				end
			end else begin
				vtx.ready <= 1'b1;
			end
		end
	end

	// End of run and watchdog
	initial begin
		cycle_count = 0;
		while (!(stimulus_done && expected_vertices.size() == 0) && cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			repeat (20) @(posedge clk);
			if (fail_count == 0) begin
				$display("TB_OK");
			end else begin
				$display("TB_ERROR");
			end
			$finish;
		end
	end

endmodule

`default_nettype wire
